// File: rtl/utf8_stream_validator_macros.svh
// Assertion macros for the UTF-8 stream validator checker.
// Included by utf8sv_checker.sv; expects i_clk and i_rst_n in scope.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

// same-cycle implication, masked during reset
`define U8SV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8sv assertion failed");

// next-cycle implication, masked during reset
`define U8SV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8sv assertion failed");

// next-cycle implication, always active (reset behavior)
`define U8SV_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("utf8sv assertion failed");

`endif

// File: rtl/utf8sv_pkg.sv
// Shared types for the UTF-8 stream validator.
// Used by the front classifier, the queue and the back-end checker.
package utf8sv_pkg;

    typedef enum logic [2:0] {
        LK_OTHER,
        LK_E0,
        LK_ED,
        LK_F0,
        LK_F4
    } t_lead_kind;

    // one byte after classification
    typedef struct packed {
        logic       fin;
        logic       invalid_lead;
        logic       is_cont;
        logic       lead_fault;
        t_lead_kind lead_kind;
        logic [1:0] cont_need;
        logic       sec_80_9f;
        logic       sec_a0_bf;
        logic       sec_80_8f;
    } t_cls;

endpackage

// File: rtl/utf8_stream_validator.sv
// UTF-8 stream validator: one byte per cycle unless stalled, verdict on the final byte.
// Path: a final byte passes the front register, the queue and the back-end result
// register before its verdict shows.
// Throughput: unless stalled, one byte in and one queue entry retired per cycle.
// Reset: synchronous active-low i_rst_n clears all sequence state and empties the queue.
module utf8_stream_validator #(
    parameter int POSITION_BITS = 32,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_final,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_valid,
    output logic [31:0] o_error_offset
);
    import utf8sv_pkg::*;

    logic w_push, w_full, w_q_valid, w_pop;
    t_cls w_front_item, w_q_item;

    utf8sv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_is_final  (i_is_final),
        .o_push      (w_push),
        .o_item      (w_front_item),
        .i_full      (w_full)
    );

    utf8sv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    utf8sv_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_item         (w_q_item),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_valid     (o_is_valid),
        .o_error_offset (o_error_offset)
    );

endmodule

// File: rtl/utf8sv_front.sv
// Front end: takes raw bytes and registers their classification.
// Depends on utf8sv_pkg; feeds utf8sv_queue.
module utf8sv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_is_final,
    output logic              o_push,
    output utf8sv_pkg::t_cls  o_item,
    input  logic              i_full
);
    import utf8sv_pkg::*;

    logic r_valid, n_valid;
    t_cls r_item, n_item;
    logic w_accept;

    assign o_in_stall = r_valid && i_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;
    assign o_item     = r_item;

    always_comb begin
        logic [7:0] b;
        b = i_data_byte;
        n_item.fin          = i_is_final;
        n_item.is_cont      = (b & 8'hC0) == 8'h80;
        n_item.sec_80_9f    = (b & 8'hE0) == 8'h80;
        n_item.sec_a0_bf    = (b & 8'hE0) == 8'hA0;
        n_item.sec_80_8f    = (b & 8'hF0) == 8'h80;
        n_item.invalid_lead = 1'b0;
        n_item.cont_need    = 2'd0;
        // two-byte leads below C2 and four-byte leads above F4 are faults
        n_item.lead_fault   = ((b & 8'hE0) == 8'hC0 && b < 8'hC2) ||
                              ((b & 8'hF8) == 8'hF0 && b > 8'hF4);
        if ((b & 8'h80) == 8'h00) begin
            n_item.cont_need = 2'd0;
        end else if ((b & 8'hE0) == 8'hC0) begin
            n_item.cont_need = 2'd1;
        end else if ((b & 8'hF0) == 8'hE0) begin
            n_item.cont_need = 2'd2;
        end else if ((b & 8'hF8) == 8'hF0) begin
            n_item.cont_need = 2'd3;
        end else begin
            n_item.invalid_lead = 1'b1;
        end
        case (b)
            8'hE0:   n_item.lead_kind = LK_E0;
            8'hED:   n_item.lead_kind = LK_ED;
            8'hF0:   n_item.lead_kind = LK_F0;
            8'hF4:   n_item.lead_kind = LK_F4;
            default: n_item.lead_kind = LK_OTHER;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

// File: rtl/utf8sv_queue.sv
// Short queue of classified bytes between front and back.
// Depends on utf8sv_pkg.
module utf8sv_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utf8sv_pkg::t_cls  i_item,
    output logic              o_full,
    output logic              o_valid,
    output utf8sv_pkg::t_cls  o_item,
    input  logic              i_pop
);
    import utf8sv_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push, w_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/utf8sv_back.sv
// Back end: sequence tracking, error capture and the result register.
// Depends on utf8sv_pkg; pops classified bytes from utf8sv_queue.
module utf8sv_back #(
    parameter int POSITION_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  utf8sv_pkg::t_cls  i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_is_valid,
    output logic [31:0]       o_error_offset
);
    import utf8sv_pkg::*;

    localparam int PB = POSITION_BITS;

    logic [PB-1:0] r_pos, n_pos;
    logic [1:0]    r_cont, n_cont;
    t_lead_kind    r_kind, n_kind;
    logic          r_await, n_await;
    logic [PB-1:0] r_start, n_start;
    logic          r_fault, n_fault;
    logic          r_err, n_err;
    logic [PB-1:0] r_err_off, n_err_off;
    logic          r_out_valid, n_out_valid;
    logic          r_is_valid, n_is_valid;
    logic [31:0]   r_off, n_off;
    logic          w_take, w_res;
    logic [PB-1:0] w_pos_inc;
    logic [63:0]   w_off_ext;

    assign w_take    = i_valid && !(i_item.fin && r_out_valid && i_out_stall);
    assign w_res     = w_take && i_item.fin;
    assign o_pop     = w_take;
    assign w_pos_inc = (r_pos == '1) ? r_pos : r_pos + 1'b1;

    assign o_out_valid    = r_out_valid;
    assign o_is_valid     = r_is_valid;
    assign o_error_offset = r_off;

    always_comb begin
        logic f;
        f         = r_fault;
        n_pos     = r_pos;
        n_cont    = r_cont;
        n_kind    = r_kind;
        n_await   = r_await;
        n_start   = r_start;
        n_fault   = r_fault;
        n_err     = r_err;
        n_err_off = r_err_off;
        w_off_ext = '0;
        n_is_valid = r_is_valid;
        n_off      = r_off;
        if (w_take) begin
            if (!r_err) begin
                if (r_cont == 2'd0) begin
                    if (i_item.invalid_lead) begin
                        n_err     = 1'b1;
                        n_err_off = r_pos;
                    end else if (i_item.cont_need != 2'd0) begin
                        n_cont  = i_item.cont_need;
                        n_kind  = i_item.lead_kind;
                        n_start = r_pos;
                        n_await = 1'b1;
                        n_fault = i_item.lead_fault;
                    end
                end else if (!i_item.is_cont) begin
                    n_err     = 1'b1;
                    n_err_off = r_pos;
                end else begin
                    if (r_await) begin
                        // overlong, surrogate and above-range second bytes
                        case (r_kind)
                            LK_E0:   f = r_fault || i_item.sec_80_9f;
                            LK_ED:   f = r_fault || i_item.sec_a0_bf;
                            LK_F0:   f = r_fault || i_item.sec_80_8f;
                            LK_F4:   f = r_fault || !i_item.sec_80_8f;
                            default: f = r_fault;
                        endcase
                        n_await = 1'b0;
                    end
                    n_fault = f;
                    n_cont  = r_cont - 1'b1;
                    if (n_cont == 2'd0 && f) begin
                        n_err     = 1'b1;
                        n_err_off = r_start;
                    end
                end
            end
            if (!i_item.fin) begin
                n_pos = w_pos_inc;
            end else begin
                // string ends inside a sequence: truncation at its length
                if (!n_err && n_cont != 2'd0) begin
                    n_err     = 1'b1;
                    n_err_off = w_pos_inc;
                end
                w_off_ext  = n_err ? 64'(n_err_off) : '0;
                n_is_valid = !n_err;
                n_off      = (|w_off_ext[63:32]) ? 32'hFFFF_FFFF : w_off_ext[31:0];
                n_pos      = '0;
                n_cont     = 2'd0;
                n_kind     = LK_OTHER;
                n_await    = 1'b0;
                n_start    = '0;
                n_fault    = 1'b0;
                n_err      = 1'b0;
                n_err_off  = '0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_cont      <= 2'd0;
            r_kind      <= LK_OTHER;
            r_await     <= 1'b0;
            r_start     <= '0;
            r_fault     <= 1'b0;
            r_err       <= 1'b0;
            r_err_off   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_cont      <= n_cont;
            r_kind      <= n_kind;
            r_await     <= n_await;
            r_start     <= n_start;
            r_fault     <= n_fault;
            r_err       <= n_err;
            r_err_off   <= n_err_off;
            r_out_valid <= n_out_valid;
        end
        if (w_res) begin
            r_is_valid <= n_is_valid;
            r_off      <= n_off;
        end
    end

endmodule

// File: rtl/utf8sv_checker.sv
// Port-level checker for utf8_stream_validator, bound to the top level.
// Depends on utf8_stream_validator_macros.svh.
`include "utf8_stream_validator_macros.svh"

module utf8sv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_is_final,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_is_valid,
    input logic [31:0] o_error_offset
);

    logic [8:0]  w_request;
    logic [32:0] w_verdict;

    assign w_request = {i_is_final, i_data_byte};
    assign w_verdict = {o_is_valid, o_error_offset};

    // stalled request holds
    `U8SV_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(w_request))

    // stalled verdict holds
    `U8SV_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(w_verdict))

    // a good string always reports offset zero
    `U8SV_ASSERT_NOW(a_valid_zero_off, o_out_valid && o_is_valid, o_error_offset == 32'd0)

    // reset drops any pending verdict
    `U8SV_ASSERT_ALWAYS(a_reset_clears, !i_rst_n, !o_out_valid)

endmodule

bind utf8_stream_validator utf8sv_checker u_checker (.*);
